// File: rtl/dct_pkg.sv
package dct_pkg;

  localparam int unsigned MaxResults = 8;

  localparam logic [3:0] KIND_NEWLINE = 4'd0;
  localparam logic [3:0] KIND_COLON   = 4'd1;
  localparam logic [3:0] KIND_LPAREN  = 4'd2;
  localparam logic [3:0] KIND_RPAREN  = 4'd3;
  localparam logic [3:0] KIND_LBRACE  = 4'd4;
  localparam logic [3:0] KIND_RBRACE  = 4'd5;
  localparam logic [3:0] KIND_DOLLAR  = 4'd6;
  localparam logic [3:0] KIND_ARROW   = 4'd7;
  localparam logic [3:0] KIND_SECTION = 4'd8;
  localparam logic [3:0] KIND_STRING  = 4'd9;
  localparam logic [3:0] KIND_CREATE  = 4'd10;
  localparam logic [3:0] KIND_BOOLEAN = 4'd11;
  localparam logic [3:0] KIND_IDENT   = 4'd12;
  localparam logic [3:0] KIND_NUMBER  = 4'd13;
  localparam logic [3:0] KIND_ERROR   = 4'd14;

  localparam logic [2:0] SectLen    = 3'd5;
  localparam logic [2:0] CreateLen  = 3'd6;
  localparam logic [2:0] BooleanLen = 3'd7;

  typedef struct packed {
    logic       op;
    logic [7:0] in_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic       has_char;
    logic [7:0] out_char;
    logic       last_of_token;
  } out_item_t;

  typedef struct packed {
    logic [3:0]                      count;
    out_item_t [MaxResults-1:0]      items;
  } group_t;

  function automatic logic [7:0] sect_char(logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      3'd0:              ch = "<";
      3'd1, 3'd2, 3'd3:  ch = "-";
      3'd4:              ch = ">";
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_char(logic sel, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (sel) begin
      unique case (idx)
        3'd0:       ch = "b";
        3'd1, 3'd2: ch = "o";
        3'd3:       ch = "l";
        3'd4:       ch = "e";
        3'd5:       ch = "a";
        3'd6:       ch = "n";
        default:    ch = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0:       ch = "c";
        3'd1:       ch = "r";
        3'd2, 3'd5: ch = "e";
        3'd3:       ch = "a";
        3'd4:       ch = "t";
        default:    ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

// File: rtl/dsl_character_tokenizer.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (op, in_char)
// out     | output    | out_valid_o / out_ready_i| out_data_o (token_kind, has_char,
//         |           |                          |  out_char, last_of_token)
// one input character per cycle while the queue has room; it is registered, tokenized
// from that register, and its results (zero to eight) enter a queue of result groups,
// Depth groups deep; results leave one per cycle from the queue head while out_ready_i
// is high, so n results make n transfers; keyword flushes are the long groups
// reset clears the lexer state, the input register and the queue; no clearing pass
// a stalled output fills the queue, then in_ready_o drops until a group drains
module dsl_character_tokenizer
  import dct_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic              in_valid_q, in_valid_d;
  in_item_t          in_q;
  logic              step;
  group_t            grp;
  logic              push, pop, full, empty;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        idx_q, idx_d;
  group_t            fifo_q [Depth];
  group_t            head;
  logic              out_xfer, head_done;

  dct_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .grp_o  (grp)
  );

  assign full       = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);
  assign step       = in_valid_q && !full;
  assign in_ready_o = !in_valid_q || step;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !step);
  assign push       = step && (grp.count != 4'd0);

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = !empty;
  assign out_data_o  = head.items[idx_q];
  assign out_xfer    = out_valid_o && out_ready_i;
  assign head_done   = ({1'b0, idx_q} + 4'd1) == head.count;
  assign pop         = out_xfer && head_done;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (out_xfer) begin
      idx_d = head_done ? 3'd0 : idx_q + 3'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= grp;
    end
  end

endmodule

// File: rtl/dct_lexer.sv
module dct_lexer
  import dct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output group_t   grp_o
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_DASH    = 4'd3;
  localparam logic [3:0] M_SECT    = 4'd4;
  localparam logic [3:0] M_STRING  = 4'd5;
  localparam logic [3:0] M_KW      = 4'd6;
  localparam logic [3:0] M_IDENT   = 4'd7;
  localparam logic [3:0] M_NUMBER  = 4'd8;

  typedef struct packed {
    logic [3:0] mode;
    logic [2:0] mcount;
    logic       ksel;
    logic       halted;
  } lex_st_t;

  typedef struct packed {
    lex_st_t st;
    group_t  grp;
  } step_t;

  lex_st_t st_q, st_d;
  step_t   res;

  function automatic out_item_t mk(logic [3:0] kind, logic has, logic [7:0] ch, logic last);
    out_item_t it;
    it.token_kind    = kind;
    it.has_char      = has;
    it.out_char      = ch;
    it.last_of_token = last;
    return it;
  endfunction

  function automatic step_t push(step_t s, out_item_t it);
    step_t r;
    r = s;
    if (r.grp.count < 4'(MaxResults)) begin
      r.grp.items[r.grp.count[2:0]] = it;
      r.grp.count = r.grp.count + 4'd1;
    end
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic step_t fail(step_t s, logic [7:0] c);
    step_t r;
    r = push(s, mk(KIND_ERROR, 1'b1, c, 1'b1));
    r.st.halted = 1'b1;
    r.st.mode   = M_IDLE;
    r.st.mcount = 3'd0;
    return r;
  endfunction

  function automatic step_t start_token(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    r.st.mode   = M_IDLE;
    r.st.mcount = 3'd0;
    case (c)
      " ":          r = r;
      "/":          r.st.mode = M_SLASH;
      8'h0D, 8'h0A: r = push(r, mk(KIND_NEWLINE, 1'b0, 8'h00, 1'b1));
      ":":          r = push(r, mk(KIND_COLON, 1'b0, 8'h00, 1'b1));
      "(":          r = push(r, mk(KIND_LPAREN, 1'b0, 8'h00, 1'b1));
      ")":          r = push(r, mk(KIND_RPAREN, 1'b0, 8'h00, 1'b1));
      "{":          r = push(r, mk(KIND_LBRACE, 1'b0, 8'h00, 1'b1));
      "}":          r = push(r, mk(KIND_RBRACE, 1'b0, 8'h00, 1'b1));
      "$":          r = push(r, mk(KIND_DOLLAR, 1'b0, 8'h00, 1'b1));
      "-":          r.st.mode = M_DASH;
      "<": begin
        r.st.mode   = M_SECT;
        r.st.mcount = 3'd1;
      end
      8'h22:        r.st.mode = M_STRING;
      "c": begin
        r.st.mode   = M_KW;
        r.st.ksel   = 1'b0;
        r.st.mcount = 3'd1;
      end
      "b": begin
        r.st.mode   = M_KW;
        r.st.ksel   = 1'b1;
        r.st.mcount = 3'd1;
      end
      default: begin
        if (is_alpha(c)) begin
          r.st.mode = M_IDENT;
          r = push(r, mk(KIND_IDENT, 1'b1, c, 1'b0));
        end else if (is_digit(c)) begin
          r.st.mode = M_NUMBER;
          r = push(r, mk(KIND_NUMBER, 1'b1, c, 1'b0));
        end else begin
          r = fail(r, c);
        end
      end
    endcase
    return r;
  endfunction

  function automatic step_t ident_next(step_t s, logic eol, logic [7:0] c);
    step_t r;
    r = s;
    if (!eol && (is_alpha(c) || is_digit(c))) begin
      r = push(r, mk(KIND_IDENT, 1'b1, c, 1'b0));
    end else begin
      r = push(r, mk(KIND_IDENT, 1'b0, 8'h00, 1'b1));
      r.st.mode = M_IDLE;
      if (!eol) r = start_token(r, c);
    end
    return r;
  endfunction

  always_comb begin
    logic       eol;
    logic [7:0] c;
    logic [2:0] len;
    logic [2:0] mc;
    eol = item_i.op;
    c   = item_i.in_char;
    len = st_q.ksel ? BooleanLen : CreateLen;
    mc  = (st_q.mcount > len) ? len : st_q.mcount;
    res = '0;
    res.st = st_q;
    if (!st_q.halted) begin
      unique case (st_q.mode)
        M_SLASH: begin
          if (!eol && c == "/") begin
            res = push(res, mk(KIND_NEWLINE, 1'b0, 8'h00, 1'b1));
            res.st.mode = M_COMMENT;
          end else begin
            res = fail(res, "/");
          end
        end
        M_COMMENT: begin
          if (eol) res.st.mode = M_IDLE;
        end
        M_DASH: begin
          if (!eol && c == ">") begin
            res = push(res, mk(KIND_ARROW, 1'b0, 8'h00, 1'b1));
            res.st.mode = M_IDLE;
          end else begin
            res = fail(res, "-");
          end
        end
        M_SECT: begin
          if (st_q.mcount < SectLen && !eol && c == sect_char(st_q.mcount)) begin
            res.st.mcount = st_q.mcount + 3'd1;
            if (res.st.mcount >= SectLen) begin
              res = push(res, mk(KIND_SECTION, 1'b0, 8'h00, 1'b1));
              res.st.mode   = M_IDLE;
              res.st.mcount = 3'd0;
            end
          end else begin
            res = fail(res, "<");
          end
        end
        M_STRING: begin
          if (eol || c == 8'h22) begin
            res = push(res, mk(KIND_STRING, 1'b0, 8'h00, 1'b1));
            res.st.mode = M_IDLE;
          end else begin
            res = push(res, mk(KIND_STRING, 1'b1, c, 1'b0));
          end
        end
        M_KW: begin
          if (mc < len && !eol && c == kw_char(st_q.ksel, mc)) begin
            res.st.mcount = mc + 3'd1;
            if (res.st.mcount >= len) begin
              res = push(res, mk(st_q.ksel ? KIND_BOOLEAN : KIND_CREATE,
                                 1'b0, 8'h00, 1'b1));
              res.st.mode   = M_IDLE;
              res.st.mcount = 3'd0;
            end
          end else begin
            // matched prefix flushed as identifier characters
            for (int i = 0; i < MaxResults - 1; i++) begin
              if (3'(i) < mc) begin
                res.grp.items[i] = mk(KIND_IDENT, 1'b1, kw_char(st_q.ksel, 3'(i)), 1'b0);
              end
            end
            res.grp.count = {1'b0, mc};
            res.st.mcount = 3'd0;
            res.st.mode   = M_IDENT;
            res = ident_next(res, eol, c);
          end
        end
        M_IDENT: res = ident_next(res, eol, c);
        M_NUMBER: begin
          if (!eol && (is_digit(c) || (c >= "A" && c <= "F"))) begin
            res = push(res, mk(KIND_NUMBER, 1'b1, c, 1'b0));
          end else begin
            res = push(res, mk(KIND_NUMBER, 1'b0, 8'h00, 1'b1));
            res.st.mode = M_IDLE;
            if (!eol) res = start_token(res, c);
          end
        end
        default: begin
          res.st.mode = M_IDLE;
          if (!eol) res = start_token(res, c);
        end
      endcase
    end
  end

  assign st_d  = step_i ? res.st : st_q;
  assign grp_o = res.grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dct_pkg::*;

  typedef enum logic [3:0] {
    LEX_IDLE,
    LEX_SLASH,
    LEX_COMMENT,
    LEX_DASH,
    LEX_SECT,
    LEX_STRING,
    LEX_KEYWORD,
    LEX_IDENT,
    LEX_NUMBER
  } lex_mode_e;

  typedef enum int unsigned {
    BAD_SLASH,
    BAD_ARROW,
    BAD_SECTION,
    BAD_ZERO,
    BAD_CHAR,
    BAD_AFTER_TOKEN
  } bad_line_e;

  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [3:0] kind;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  lex_mode_e   lex_mode;
  logic [2:0]  matched;
  logic        boolean_sel;
  bit          halted;
  out_item_t   step_tokens[$];
  out_item_t   expected_tokens[$];
  out_item_t   head;
  in_item_t    line_q[$];
  plan_row_t   plan[$];
  bit          calm;
  int unsigned mismatches;

  dsl_character_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void emit_token(logic [3:0] kind, logic has, logic [7:0] ch, logic last);
    out_item_t r;
    if (step_tokens.size() >= MaxResults) return;
    r.token_kind    = kind;
    r.has_char      = has;
    r.out_char      = ch;
    r.last_of_token = last;
    step_tokens.insert(step_tokens.size(), r);
  endfunction

  function automatic void raise_error(logic [7:0] ch);
    emit_token(KIND_ERROR, 1'b1, ch, 1'b1);
    halted   = 1'b1;
    lex_mode = LEX_IDLE;
    matched  = 3'd0;
  endfunction

  function automatic bit is_word_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void start_token(logic [7:0] c);
    lex_mode = LEX_IDLE;
    matched  = 3'd0;
    case (c)
      " ": ;
      "/": lex_mode = LEX_SLASH;
      8'h0d, 8'h0a: emit_token(KIND_NEWLINE, 1'b0, 8'h00, 1'b1);
      ":": emit_token(KIND_COLON, 1'b0, 8'h00, 1'b1);
      "(": emit_token(KIND_LPAREN, 1'b0, 8'h00, 1'b1);
      ")": emit_token(KIND_RPAREN, 1'b0, 8'h00, 1'b1);
      "{": emit_token(KIND_LBRACE, 1'b0, 8'h00, 1'b1);
      "}": emit_token(KIND_RBRACE, 1'b0, 8'h00, 1'b1);
      "$": emit_token(KIND_DOLLAR, 1'b0, 8'h00, 1'b1);
      "-": lex_mode = LEX_DASH;
      "<": begin
        lex_mode = LEX_SECT;
        matched  = 3'd1;
      end
      8'h22: lex_mode = LEX_STRING;
      "c", "b": begin
        lex_mode    = LEX_KEYWORD;
        boolean_sel = (c == "b");
        matched     = 3'd1;
      end
      default: begin
        if (is_word_start(c)) begin
          lex_mode = LEX_IDENT;
          emit_token(KIND_IDENT, 1'b1, c, 1'b0);
        end else if (is_digit(c)) begin
          lex_mode = LEX_NUMBER;
          emit_token(KIND_NUMBER, 1'b1, c, 1'b0);
        end else begin
          raise_error(c);
        end
      end
    endcase
  endfunction

  function automatic void ident_next(bit eol, logic [7:0] c);
    if (!eol && (is_word_start(c) || is_digit(c))) begin
      emit_token(KIND_IDENT, 1'b1, c, 1'b0);
      return;
    end
    emit_token(KIND_IDENT, 1'b0, 8'h00, 1'b1);
    lex_mode = LEX_IDLE;
    if (!eol) start_token(c);
  endfunction

  // results caused by one accepted character or end of line, into step_tokens
  function automatic void tokenize(in_item_t it);
    bit          eol;
    logic [7:0]  c;
    string       sect;
    string       kw;
    int unsigned kw_len;
    eol  = it.op;
    c    = it.in_char;
    sect = "<--->";
    step_tokens.delete();
    if (halted) return;
    case (lex_mode)
      LEX_SLASH: begin
        if (!eol && c == "/") begin
          emit_token(KIND_NEWLINE, 1'b0, 8'h00, 1'b1);
          lex_mode = LEX_COMMENT;
        end else begin
          raise_error("/");
        end
      end
      LEX_COMMENT: if (eol) lex_mode = LEX_IDLE;
      LEX_DASH: begin
        if (!eol && c == ">") begin
          emit_token(KIND_ARROW, 1'b0, 8'h00, 1'b1);
          lex_mode = LEX_IDLE;
        end else begin
          raise_error("-");
        end
      end
      LEX_SECT: begin
        if (matched < 3'd5 && !eol && c == sect[matched]) begin
          matched++;
          if (matched >= 3'd5) begin
            emit_token(KIND_SECTION, 1'b0, 8'h00, 1'b1);
            lex_mode = LEX_IDLE;
            matched  = 3'd0;
          end
        end else begin
          raise_error("<");
        end
      end
      LEX_STRING: begin
        if (eol || c == 8'h22) begin
          emit_token(KIND_STRING, 1'b0, 8'h00, 1'b1);
          lex_mode = LEX_IDLE;
        end else begin
          emit_token(KIND_STRING, 1'b1, c, 1'b0);
        end
      end
      LEX_KEYWORD: begin
        if (boolean_sel) kw = "boolean";
        else kw = "create";
        kw_len = kw.len();
        if (matched > kw_len) matched = kw_len[2:0];
        if (matched < kw_len && !eol && c == kw[matched]) begin
          matched++;
          if (matched >= kw_len) begin
            emit_token(boolean_sel ? KIND_BOOLEAN : KIND_CREATE, 1'b0, 8'h00, 1'b1);
            lex_mode = LEX_IDLE;
            matched  = 3'd0;
          end
        end else begin
          // partial keyword goes out as identifier text
          for (int i = 0; i < matched; i++) emit_token(KIND_IDENT, 1'b1, kw[i], 1'b0);
          matched  = 3'd0;
          lex_mode = LEX_IDENT;
          ident_next(eol, c);
        end
      end
      LEX_IDENT: ident_next(eol, c);
      LEX_NUMBER: begin
        if (!eol && (is_digit(c) || (c >= "A" && c <= "F"))) begin
          emit_token(KIND_NUMBER, 1'b1, c, 1'b0);
        end else begin
          emit_token(KIND_NUMBER, 1'b0, 8'h00, 1'b1);
          lex_mode = LEX_IDLE;
          if (!eol) start_token(c);
        end
      end
      default: begin
        lex_mode = LEX_IDLE;
        if (!eol) start_token(c);
      end
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c);
    line_q.insert(line_q.size(), {1'b0, c});
  endfunction

  function automatic void add_eol();
    line_q.insert(line_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] word_char(bit with_digits);
    string set;
    set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    return set[$urandom_range(0, with_digits ? 62 : 52)];
  endfunction

  function automatic logic [7:0] any_but_quote();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == 8'h22);
    return c;
  endfunction

  // one well-formed source line of random tokens
  function automatic void gen_line();
    int unsigned n_tok;
    int unsigned len;
    string       word;
    string       punct;
    string       hex;
    punct = ":(){}$";
    hex   = "0123456789ABCDEF";
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 12))
        0, 1: add_char(punct[$urandom_range(0, 5)]);
        2: begin
          add_char("-");
          add_char(">");
        end
        3: begin
          word = "<--->";
          for (int k = 0; k < 5; k++) add_char(word[k]);
        end
        4, 5: begin
          if ($urandom_range(0, 1)) word = "boolean";
          else word = "create";
          len  = $urandom_range(0, 2) == 0 ? word.len() : $urandom_range(1, word.len());
          for (int k = 0; k < len; k++) add_char(word[k]);
          if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) add_char(word_char(1'b1));
          end
        end
        6: begin
          add_char(word_char(1'b0));
          repeat ($urandom_range(0, 5)) add_char(word_char(1'b1));
        end
        7: begin
          if ($urandom_range(0, 3) == 0) begin
            add_char("0");
            add_char("x");
          end else begin
            add_char(8'("0" + $urandom_range(0, 9)));
          end
          repeat ($urandom_range(0, 4)) add_char(hex[$urandom_range(0, 15)]);
        end
        8: begin
          add_char(8'h22);
          repeat ($urandom_range(0, 6)) add_char(any_but_quote());
          if ($urandom_range(0, 3) == 0) begin
            add_eol();
            return;
          end
          add_char(8'h22);
        end
        9: add_char($urandom_range(0, 1) ? 8'h0d : 8'h0a);
        10: begin
          add_char("/");
          add_char("/");
          repeat ($urandom_range(0, 8)) add_char(8'($urandom_range(0, 255)));
          add_eol();
          return;
        end
        default: add_char(" ");
      endcase
    end
    add_eol();
  endfunction

  function automatic void add_row(bit op, logic [7:0] ch, bit typed, logic [3:0] kind);
    plan_row_t r;
    r.item  = {op, ch};
    r.typed = typed;
    r.kind  = kind;
    plan.insert(plan.size(), r);
  endfunction

  task automatic send(in_item_t it, bit typed, logic [3:0] kind);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize(it);
    if (typed) begin
      step_tokens.delete();
      emit_token(kind, 1'b0, 8'h00, 1'b1);
    end
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (expected_tokens.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token_kind: expected no transfer, got %0d", out_data_o.token_kind);
        mismatches++;
      end else begin
        head = expected_tokens.pop_front();
        check_field("token_kind", head.token_kind, out_data_o.token_kind);
        check_field("has_char", head.has_char, out_data_o.has_char);
        check_field("out_char", head.out_char, out_data_o.out_char);
        check_field("last_of_token", head.last_of_token, out_data_o.last_of_token);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    bad_line_e   bad;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    mismatches  = 0;
    lex_mode    = LEX_IDLE;
    matched     = 3'd0;
    boolean_sel = 1'b0;
    halted      = 1'b0;
    sent        = 0;

    add_row(1'b0, ":", 1'b1, KIND_COLON);
    add_row(1'b0, "(", 1'b1, KIND_LPAREN);
    add_row(1'b0, ")", 1'b1, KIND_RPAREN);
    add_row(1'b0, "$", 1'b1, KIND_DOLLAR);
    add_row(1'b0, "-", 1'b0, KIND_NEWLINE);
    add_row(1'b0, ">", 1'b1, KIND_ARROW);
    add_row(1'b0, "<", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "-", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "-", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "-", 1'b0, KIND_NEWLINE);
    add_row(1'b0, ">", 1'b1, KIND_SECTION);
    add_row(1'b0, "c", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "r", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "e", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "a", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "t", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "e", 1'b1, KIND_CREATE);
    add_row(1'b0, 8'h0d, 1'b1, KIND_NEWLINE);
    add_row(1'b0, "9", 1'b0, KIND_NEWLINE);
    add_row(1'b0, "F", 1'b0, KIND_NEWLINE);
    add_row(1'b1, 8'hff, 1'b0, KIND_NEWLINE);
    add_row(1'b0, 8'h22, 1'b0, KIND_NEWLINE);
    add_row(1'b0, 8'hff, 1'b0, KIND_NEWLINE);
    add_row(1'b1, 8'h00, 1'b0, KIND_NEWLINE);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].kind);
    drain();

    while (sent < 280) begin
      calm = ($urandom_range(0, 3) == 0);
      gen_line();
      while (line_q.size() > 0) begin
        send(line_q.pop_front(), 1'b0, KIND_NEWLINE);
        sent++;
      end
    end

    // the block stops for good on an error, so exactly one ends the run
    drain();
    calm = 1'b1;
    bad  = bad_line_e'($urandom_range(0, 5));
    case (bad)
      BAD_SLASH: begin
        add_char("/");
        if ($urandom_range(0, 1)) add_eol();
        else add_char(word_char(1'b1));
      end
      BAD_ARROW: begin
        add_char("-");
        if ($urandom_range(0, 1)) add_eol();
        else add_char(word_char(1'b1));
      end
      BAD_SECTION: begin
        add_char("<");
        add_char("-");
        if ($urandom_range(0, 1)) add_eol();
        else add_char(">");
      end
      BAD_ZERO: add_char(8'h00);
      BAD_CHAR: add_char($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : "#");
      default: begin
        if ($urandom_range(0, 1)) begin
          add_char("a");
          add_char("b");
        end else begin
          add_char("7");
        end
        add_char(8'h09);
      end
    endcase
    repeat (4) line_q.insert(line_q.size(), 9'($urandom_range(0, 511)));
    while (line_q.size() > 0) send(line_q.pop_front(), 1'b0, KIND_NEWLINE);

    in_valid_i <= 1'b0;
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/dct_pkg.sv
rtl/dct_lexer.sv
rtl/dsl_character_tokenizer.sv
dv/tb_top.sv
